// ----- design/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types and constants of the SHA-256 stream hash.
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int unsigned BLK_BITS = 512;

	// One block job handed from the front to the compression core.
	typedef struct packed {
		logic                last_blk;  // emit digest and reinitialize after it
		logic [BLK_BITS-1:0] blk;       // byte 0 in the top bits
	} sha_job_t;

	typedef logic [7:0][31:0] sha_hash_t;  // index 0 is word H0

	localparam sha_hash_t SHA_IV = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	function automatic logic [31:0] round_k(input logic [5:0] idx);
		logic [31:0] k;
		case (idx)
			6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

endpackage

// ----- design/sha_front.sv -----
// ----------------------------------------------------------------------------
// sha_front
// Byte intake: fill the 64-byte block, pad at end of message, queue jobs.
// ----------------------------------------------------------------------------
module sha_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        s_tdata,
	input  logic              s_tuser,
	input  logic              s_tlast,
	input  logic              s_tvalid,
	output logic              s_tready,
	output sha_pkg::sha_job_t job,
	output logic              job_valid,
	input  logic              job_ready
);

	typedef enum logic [3:0] {
		F_IN   = 4'b0001,
		F_FULL = 4'b0010,
		F_PAD  = 4'b0100,
		F_LEN  = 4'b1000
	} front_state_t;

	front_state_t      state_q;
	logic [63:0][7:0]  buf_q;
	logic [5:0]        fill_q;
	logic [63:0]       cnt_q;
	logic              eom_q;
	logic [63:0]       total;
	logic              with_len;
	logic [511:0]      pad_blk;
	logic              push;

	assign total    = cnt_q + {55'd0, fill_q, 3'd0};
	assign with_len = (state_q == F_LEN) || (fill_q < 6'd56);

	// Byte i sits at bits [511-8i -: 8].
	always_comb begin
		for (int i = 0; i < 64; i++) begin
			logic [7:0] b;
			if (state_q == F_FULL) begin
				b = buf_q[i];
			end else if (state_q == F_LEN) begin
				b = 8'h00;
			end else if (6'(i) < fill_q) begin
				b = buf_q[i];
			end else if (6'(i) == fill_q) begin
				b = 8'h80;
			end else begin
				b = 8'h00;
			end
			if (state_q != F_FULL && with_len && i >= 56) begin
				b = total[8*(63-i) +: 8];
			end
			pad_blk[511-8*i -: 8] = b;
		end
	end

	assign s_tready     = (state_q == F_IN);
	assign job_valid    = (state_q != F_IN);
	assign job.blk      = pad_blk;
	assign job.last_blk = (state_q != F_FULL) && with_len;
	assign push         = job_valid && job_ready;

	always_ff @(posedge clk) begin
		if (state_q == F_IN && s_tvalid && s_tuser) begin
			buf_q[fill_q] <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IN;
			fill_q  <= '0;
			cnt_q   <= '0;
			eom_q   <= 1'b0;
		end else begin
			case (state_q)
				F_IN: begin
					if (s_tvalid) begin
						if (s_tuser) begin
							fill_q <= fill_q + 6'd1;
							if (fill_q == 6'd63) begin
								eom_q   <= s_tlast;
								state_q <= F_FULL;
							end else if (s_tlast) begin
								state_q <= F_PAD;
							end
						end else if (s_tlast) begin
							state_q <= F_PAD;
						end
					end
				end
				F_FULL: begin
					if (push) begin
						cnt_q   <= cnt_q + 64'd512;
						state_q <= eom_q ? F_PAD : F_IN;
					end
				end
				F_PAD: begin
					if (push) begin
						if (with_len) begin
							fill_q  <= '0;
							cnt_q   <= '0;
							state_q <= F_IN;
						end else begin
							state_q <= F_LEN;
						end
					end
				end
				F_LEN: begin
					if (push) begin
						fill_q  <= '0;
						cnt_q   <= '0;
						state_q <= F_IN;
					end
				end
				default: state_q <= F_IN;
			endcase
		end
	end

endmodule

// ----- design/sha_fifo.sv -----
// ----------------------------------------------------------------------------
// sha_fifo
// Two-entry block queue between intake and compression.
// ----------------------------------------------------------------------------
module sha_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  sha_pkg::sha_job_t wr_job,
	input  logic              wr_valid,
	output logic              wr_ready,
	output sha_pkg::sha_job_t rd_job,
	output logic              rd_valid,
	input  logic              rd_ready
);

	sha_pkg::sha_job_t mem_q [2];
	logic              wp_q;
	logic              rp_q;
	logic [1:0]        cnt_q;
	logic              wr_en;
	logic              rd_en;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_job   = mem_q[rp_q];
	assign wr_en    = wr_valid && wr_ready;
	assign rd_en    = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= ~wp_q;
			if (rd_en) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

endmodule

// ----- design/sha_core.sv -----
// ----------------------------------------------------------------------------
// sha_core
// Iterative SHA-256 compression, one round per cycle, and digest output.
// ----------------------------------------------------------------------------
module sha_core (
	input  logic              clk,
	input  logic              arst_n,
	input  sha_pkg::sha_job_t job,
	input  logic              job_valid,
	output logic              job_ready,
	output logic [63:0]       m_tdata,
	output logic [1:0]        m_tuser,
	output logic              m_tlast,
	output logic              m_tvalid,
	input  logic              m_tready
);

	typedef enum logic [2:0] {
		C_IDLE = 3'b001,
		C_RUN  = 3'b010,
		C_ADD  = 3'b100
	} core_state_t;

	core_state_t       state_q;
	logic [5:0]        rnd_q;
	logic              last_q;
	logic [15:0][31:0] w_q;
	sha_pkg::sha_hash_t v_q;
	sha_pkg::sha_hash_t h_q;
	sha_pkg::sha_hash_t h_sum;
	logic [255:0]      dig_q;
	logic [1:0]        idx_q;
	logic              obusy_q;
	logic [31:0]       s0, s1, w_new, big0, big1, ch, maj, t1, t2;

	assign s0    = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]}
	             ^ (w_q[1] >> 3);
	assign s1    = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
	             ^ (w_q[14] >> 10);
	assign w_new = s1 + w_q[9] + s0 + w_q[0];
	assign big1  = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
	             ^ {v_q[4][24:0], v_q[4][31:25]};
	assign ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign big0  = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
	             ^ {v_q[0][21:0], v_q[0][31:22]};
	assign maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1    = v_q[7] + big1 + ch + sha_pkg::round_k(rnd_q) + w_q[0];
	assign t2    = big0 + maj;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			h_sum[i] = h_q[i] + v_q[i];
		end
	end

	assign job_ready = (state_q == C_IDLE);
	assign m_tvalid  = obusy_q;
	assign m_tdata   = dig_q[255 - 64*idx_q -: 64];
	assign m_tuser   = idx_q;
	assign m_tlast   = (idx_q == 2'd3);

	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && job_valid) begin
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= job.blk[511-32*i -: 32];
			end
			v_q    <= h_q;
			last_q <= job.last_blk;
		end else if (state_q == C_RUN) begin
			w_q  <= {w_new, w_q[15:1]};
			v_q  <= {v_q[6:4], v_q[3] + t1, v_q[2:0], t1 + t2};
		end
		if (state_q == C_ADD && last_q && !obusy_q) begin
			for (int i = 0; i < 8; i++) begin
				dig_q[255-32*i -: 32] <= h_sum[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			rnd_q   <= '0;
			h_q     <= sha_pkg::SHA_IV;
			obusy_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (job_valid) begin
						rnd_q   <= '0;
						state_q <= C_RUN;
					end
				end
				C_RUN: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= C_ADD;
				end
				C_ADD: begin
					if (!last_q) begin
						h_q     <= h_sum;
						state_q <= C_IDLE;
					end else if (!obusy_q) begin
						h_q     <= sha_pkg::SHA_IV;
						obusy_q <= 1'b1;
						idx_q   <= '0;
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
			if (obusy_q && m_tready) begin
				idx_q <= idx_q + 2'd1;
				if (idx_q == 2'd3) obusy_q <= 1'b0;
			end
		end
	end

endmodule

// ----- design/sha256_stream_hash.sv -----
// The core takes a block job when idle and runs it through load, 64 rounds and the chaining
// add; the first digest word is valid the cycle after the final add.
// Throughput: one byte per cycle while a block fills; each block handoff holds intake
// while the block is pushed (a pad block plus a length block are pushed in turn), and the
// two-entry queue holds it longer when the core falls behind or a digest waits.
// Reset (arst_n low) clears fill, bit count and queue, and loads the initial hash.
// ----------------------------------------------------------------------------
// sha256_stream_hash
// SHA-256 over a byte stream, digest emitted as four 64-bit transactions.
// ----------------------------------------------------------------------------
module sha256_stream_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] byte_valid
	input  logic        s_tlast,   // end_of_message
	input  logic        s_tvalid,
	output logic        s_tready,
	output logic [63:0] m_tdata,   // [63:0] digest_word
	output logic [1:0]  m_tuser,   // [1:0] word_index
	output logic        m_tlast,   // last_word
	output logic        m_tvalid,
	input  logic        m_tready
);

	sha_pkg::sha_job_t f_job;
	sha_pkg::sha_job_t q_job;
	logic              f_valid, f_ready;
	logic              q_valid, q_ready;

	// Front: collect bytes, pad, hand over whole blocks.
	sha_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.job       (f_job),
		.job_valid (f_valid),
		.job_ready (f_ready)
	);

	// Queue: let intake fill the next block while the core works.
	sha_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_job   (f_job),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.rd_job   (q_job),
		.rd_valid (q_valid),
		.rd_ready (q_ready)
	);

	// Back: compress and emit the digest.
	sha_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (q_job),
		.job_valid (q_valid),
		.job_ready (q_ready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready)
	);

`ifndef SYNTHESIS
	// The fourth word, and only it, closes the digest.
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == 2'd3)))
		else $error("tlast does not match word index");

	// Words advance one by one within a digest.
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> (m_tvalid &&
		m_tuser == $past(m_tuser) + 2'd1))
		else $error("digest word skipped");

	// A digest always starts at word zero.
	a_idx_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> (m_tuser == 2'd0))
		else $error("digest does not start at word zero");
`endif

endmodule
